@@ hw/rtl/gpr_pkg.sv @@
// Package for the graph path reachability unit: payload structs, sizes and
// register codes. No dependencies.
package gpr_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 2048;
    localparam int VW = 10;
    localparam int CW = 11;

    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;

    typedef struct packed {
        logic [VW-1:0] edge_a;
        logic [VW-1:0] edge_b;
        logic          edge_present;
        logic          last_edge;
        logic [VW-1:0] source_vertex;
        logic [VW-1:0] destination_vertex;
    } gpr_in_t;

    typedef struct packed {
        logic path_found;
        logic edges_dropped;
    } gpr_out_t;

endpackage

@@ hw/rtl/gpr_search.sv @@
// Edge store, visited map, stack and the search sequencer of the unit.
// Depends on gpr_pkg.
module gpr_search
    import gpr_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [CW-1:0] vertex_count,
    input  logic          in_valid,
    output logic          in_ready,
    input  gpr_in_t       in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output gpr_out_t      out_data
);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EFW = $clog2(MAX_EDGES + 1);
    localparam int SAW = $clog2(MAX_VERTICES);
    localparam int SDW = $clog2(MAX_VERTICES + 1);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_POP   = 3'd2;
    localparam logic [2:0] ST_POPW  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2*VW-1:0] edge_mem [MAX_EDGES];
    logic [VW-1:0]   stack_mem [MAX_VERTICES];
    logic            vis_mem [MAX_VERTICES];

    logic [2:0]     state_reg, state_next;
    logic [EFW-1:0] fill_reg, fill_next;
    logic           ovf_reg, ovf_next;
    logic [SDW-1:0] sp_reg, sp_next;
    logic [EFW:0]   scan_reg, scan_next;
    logic [SAW:0]   clr_reg, clr_next;
    logic [VW-1:0]  cur_reg, cur_next;
    logic [VW-1:0]  src_reg, src_next, dst_reg, dst_next;
    logic           found_reg, found_next;
    logic           dropped_reg, dropped_next;
    logic           ov_reg, ov_next;

    // Scan pipeline: edge read, then visited read, then push.
    logic [2*VW-1:0] edge_rd;
    logic            e_vld_reg;
    logic [VW-1:0]   pv_reg;
    logic            pv_vld_reg;
    logic            vis_rd;
    logic [VW-1:0]   stack_rd;

    logic [SDW:0] count_eff;
    logic         edge_ok;
    logic         push_en;
    logic         pend_a_reg;
    logic [VW-1:0] pend_b_reg;

    always_comb
    begin
        count_eff = (vertex_count > CW'(MAX_VERTICES)) ? (SDW+1)'(MAX_VERTICES)
                                                       : (SDW+1)'(vertex_count);
        edge_ok = in_data.edge_present && ((SDW+1)'(in_data.edge_a) < count_eff)
                  && ((SDW+1)'(in_data.edge_b) < count_eff);
    end

    assign in_ready  = (state_reg == ST_LOAD) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = '{path_found: found_reg, edges_dropped: dropped_reg};

    // The second endpoint match of one edge is held back and offered in the next cycle.
    logic [VW-1:0] ea, eb;
    logic ma, mb;
    assign ea = edge_rd[VW-1:0];
    assign eb = edge_rd[2*VW-1:VW];
    assign ma = e_vld_reg && (ea == cur_reg);
    assign mb = e_vld_reg && (eb == cur_reg);

    logic          cand_vld;
    logic [VW-1:0] cand_v;
    logic          stall;
    always_comb
    begin
        // The scan address holds while an edge matching on both ends is split.
        stall = pend_a_reg || (ma && mb);
        if (pend_a_reg)
        begin
            cand_vld = 1'b1;
            cand_v   = pend_b_reg;
        end
        else if (mb)
        begin
            cand_vld = 1'b1;
            cand_v   = ea;
        end
        else
        begin
            cand_vld = ma;
            cand_v   = eb;
        end
        push_en = (state_reg == ST_SCAN) && pv_vld_reg && !vis_rd
                  && ((SDW+1)'(pv_reg) < (SDW+1)'(MAX_VERTICES));
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && in_valid && in_ready && edge_ok
            && fill_reg < EFW'(MAX_EDGES))
        begin
            edge_mem[fill_reg[EAW-1:0]] <= {in_data.edge_b, in_data.edge_a};
        end
        edge_rd  <= edge_mem[scan_reg[EAW-1:0]];
        stack_rd <= stack_mem[sp_next[SAW-1:0]];
        vis_rd   <= vis_mem[cand_v[SAW-1:0]];
        if (state_reg == ST_CLEAR)
            vis_mem[clr_reg[SAW-1:0]] <= 1'b0;
        else if (push_en)
            vis_mem[pv_reg[SAW-1:0]] <= 1'b1;
        else if (state_reg == ST_POP && sp_reg == '0 && clr_reg == '0)
            vis_mem[src_reg[SAW-1:0]] <= 1'b1;
        if (push_en)
            stack_mem[sp_reg[SAW-1:0]] <= pv_reg;
        else if (state_reg == ST_CLEAR)
            stack_mem[0] <= src_reg;
    end

    logic seeded_reg, seeded_next;

    always_comb
    begin
        state_next = state_reg;   fill_next = fill_reg; ovf_next = ovf_reg;
        sp_next = sp_reg;         scan_next = scan_reg; clr_next = clr_reg;
        cur_next = cur_reg;       src_next = src_reg;   dst_next = dst_reg;
        found_next = found_reg;   dropped_next = dropped_reg;
        ov_next = ov_reg && !out_ready;
        seeded_next = seeded_reg;
        if (push_en)
            sp_next = sp_reg + SDW'(1);
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && in_ready)
                begin
                    if (edge_ok)
                    begin
                        if (fill_reg < EFW'(MAX_EDGES))
                            fill_next = fill_reg + EFW'(1);
                        else
                            ovf_next = 1'b1;
                    end
                    if (in_data.last_edge)
                    begin
                        src_next = in_data.source_vertex;
                        dst_next = in_data.destination_vertex;
                        dropped_next = ovf_next;
                        if ((SDW+1)'(in_data.source_vertex) >= count_eff
                            || (SDW+1)'(in_data.destination_vertex) >= count_eff)
                        begin
                            found_next = 1'b0; state_next = ST_DONE;
                        end
                        else if (in_data.source_vertex == in_data.destination_vertex)
                        begin
                            found_next = 1'b1; state_next = ST_DONE;
                        end
                        else
                        begin
                            clr_next = '0; state_next = ST_CLEAR;
                        end
                    end
                end
            end
            ST_CLEAR:
            begin
                clr_next = clr_reg + (SAW+1)'(1);
                if (clr_reg == (SAW+1)'(MAX_VERTICES - 1))
                begin
                    clr_next = '0; sp_next = '0; seeded_next = 1'b0;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                // First entry: seed the source as visited and on the stack.
                if (!seeded_reg)
                begin
                    seeded_next = 1'b1;
                    sp_next = SDW'(1);
                end
                else if (sp_reg == '0)
                begin
                    found_next = 1'b0; state_next = ST_DONE;
                end
                else
                begin
                    sp_next = sp_reg - SDW'(1);
                    state_next = ST_POPW;
                end
            end
            ST_POPW:
            begin
                cur_next = stack_rd;
                if (stack_rd == dst_reg)
                begin
                    found_next = 1'b1; state_next = ST_DONE;
                end
                else
                begin
                    scan_next = '0; state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stall && scan_reg < (EFW+1)'(fill_reg))
                    scan_next = scan_reg + (EFW+1)'(1);
                if (scan_reg >= (EFW+1)'(fill_reg) && !e_vld_reg && !pv_vld_reg
                    && !pend_a_reg)
                    state_next = ST_POP;
            end
            ST_DONE:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1; fill_next = '0; ovf_next = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // A vertex seen twice in flight: the second sees vis stale, so compare.
    logic dup;
    assign dup = push_en && pv_vld_reg && (cand_v == pv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD; fill_reg <= '0; ovf_reg <= 1'b0; sp_reg <= '0;
            scan_reg <= '0; clr_reg <= '0; ov_reg <= 1'b0; e_vld_reg <= 1'b0;
            pv_vld_reg <= 1'b0; pend_a_reg <= 1'b0; seeded_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; fill_reg <= fill_next; ovf_reg <= ovf_next;
            sp_reg <= sp_next; scan_reg <= scan_next; clr_reg <= clr_next;
            ov_reg <= ov_next; seeded_reg <= seeded_next;
            if (state_reg == ST_SCAN)
            begin
                e_vld_reg <= scan_reg < (EFW+1)'(fill_reg);
                pend_a_reg <= !pend_a_reg && ma && mb;
                pv_vld_reg <= cand_vld && !dup;
            end
            else
            begin
                e_vld_reg <= 1'b0; pv_vld_reg <= 1'b0; pend_a_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next; src_reg <= src_next; dst_reg <= dst_next;
        found_reg <= found_next; dropped_reg <= dropped_next;
        pv_reg <= cand_v;
        if (!pend_a_reg)
            pend_b_reg <= eb;
    end

endmodule

@@ hw/rtl/graph_path_reachability_unit.sv @@
// Top level of the graph path reachability unit: APB register and search core.
// Depends on gpr_pkg and gpr_search.
//
//  Channel  Dir  Handshake          Payload
//  in       in   in_valid/in_ready  gpr_in_t (one edge beat)
//  out      out  out_valid/out_ready gpr_out_t (one result per query)
//  cfg      in   APB psel/penable   vertex_count at address 0
//
// A last beat whose query is decided at once (an endpoint out of range, or
// source equal to destination) goes straight to posting the result.
// Otherwise the search runs a clearing pass over the MAX_VERTICES entries of
// the visited map and seeds the source, then for each popped vertex scans the
// stored edges through the one edge memory port, the scan stalling for every
// stored edge with both ends on that vertex; an empty stack ends the search
// and the result is posted. Reset returns the control registers to their idle
// values and vertex_count to 1024. A stalled result holds and no beat is taken
// until it leaves.
module graph_path_reachability_unit
    import gpr_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  gpr_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output gpr_out_t    out_data
);
    logic [CW-1:0] vcount_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_VERTEX_COUNT) ? {21'd0, vcount_reg} : 32'd0;

    // The only register sits at address zero; other writes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcount_reg <= CW'(1024);
        else if (psel && penable && pwrite && paddr == REG_VERTEX_COUNT)
            vcount_reg <= pwdata[CW-1:0];
    end

    gpr_search #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_search (
        .clk(clk), .rst_n(rst_n), .vertex_count(vcount_reg),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule
